/* design/iswoc_pkg.sv */
`timescale 1ns / 1ps
package iswoc_pkg;

  localparam int unsigned DATA_W        = 32;
  localparam int unsigned CNT_W         = 13;
  localparam int unsigned DEPTH_DEFAULT = 64;
  localparam int unsigned OUT_TDATA_W   = 64;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD,
    ST_CMP,
    ST_PUT,
    ST_FL_RD,
    ST_FL_LD
  } state_e;

  typedef struct packed {
    logic load_in;
    logic rd_pos;
    logic shift;
    logic put;
    logic fl_rd;
    logic fl_ld;
  } cmd_t;

  typedef struct packed {
    logic pos_zero;
    logic greater;
    logic flush;
    logic out_free;
    logic k_last;
  } status_t;

endpackage

/* design/iswoc_ctrl.sv */
`timescale 1ns / 1ps
module iswoc_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  iswoc_pkg::status_t status_i,
  output iswoc_pkg::cmd_t    cmd_o
);
  import iswoc_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_RD;
      end
      ST_RD: begin
        state_d = status_i.pos_zero ? ST_PUT : ST_CMP;
      end
      ST_CMP: begin
        state_d = status_i.greater ? ST_RD : ST_PUT;
      end
      ST_PUT: begin
        state_d = status_i.flush ? ST_FL_RD : ST_IDLE;
      end
      ST_FL_RD: begin
        state_d = ST_FL_LD;
      end
      ST_FL_LD: begin
        if (status_i.out_free) state_d = status_i.k_last ? ST_IDLE : ST_FL_RD;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.load_in = in_valid_i;
      end
      ST_RD: begin
        cmd_o.rd_pos = !status_i.pos_zero;
      end
      ST_CMP: begin
        cmd_o.shift = status_i.greater;
      end
      ST_PUT: begin
        cmd_o.put = 1'b1;
      end
      ST_FL_RD: begin
        cmd_o.fl_rd = 1'b1;
      end
      ST_FL_LD: begin
        cmd_o.fl_ld = status_i.out_free;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

endmodule

/* design/iswoc_dp.sv */
`timescale 1ns / 1ps
module iswoc_dp #(
  parameter int unsigned DEPTH = iswoc_pkg::DEPTH_DEFAULT
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  iswoc_pkg::cmd_t                cmd_i,
  output iswoc_pkg::status_t             status_o,
  input  logic [iswoc_pkg::DATA_W-1:0]   in_value_i,
  input  logic                           in_last_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [iswoc_pkg::DATA_W-1:0]   out_value_o,
  output logic                           out_final_o,
  output logic [iswoc_pkg::CNT_W-1:0]    out_cmp_o,
  output logic [iswoc_pkg::CNT_W-1:0]    out_asg_o
);
  import iswoc_pkg::*;

  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW    = AW + 1;
  localparam int unsigned ST_W  = $clog2(DEPTH * (DEPTH - 1) / 2 + 1);
  localparam int unsigned SUM_W = ((ST_W > CW) ? ST_W : CW) + 1;

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rd_data_q;
  logic [AW-1:0]     rd_addr;
  logic              rd_en;
  logic [AW-1:0]     wr_addr;
  logic [DATA_W-1:0] wr_data;
  logic              wr_en;

  logic [DATA_W-1:0] val_q;
  logic              last_q;
  logic [AW-1:0]     pos_q, pos_d;
  logic [CW-1:0]     cnt_q, cnt_d;
  logic [ST_W-1:0]   shf_q, shf_d;
  logic [CW-1:0]     k_q, k_d;
  logic [CW-1:0]     cnt_inc;
  logic [SUM_W-1:0]  sum;
  logic [CNT_W-1:0]  sum_cnt;
  logic [CNT_W-1:0]  cmp_q, asg_q;

  logic              out_valid_q, out_valid_d;
  logic [DATA_W-1:0] out_value_q;
  logic              out_final_q;
  logic [CNT_W-1:0]  out_cmp_q, out_asg_q;

  assign cnt_inc = cnt_q + CW'(1);
  assign sum     = SUM_W'(cnt_inc) + SUM_W'(shf_q);
  assign sum_cnt = CNT_W'(sum);

  // memory: one write port, one registered read port
  assign rd_en   = cmd_i.rd_pos | cmd_i.fl_rd;
  assign rd_addr = cmd_i.fl_rd ? k_q[AW-1:0] : AW'(pos_q - AW'(1));
  assign wr_en   = cmd_i.shift | cmd_i.put;
  assign wr_addr = pos_q;
  assign wr_data = cmd_i.shift ? rd_data_q : val_q;

  always_ff @(posedge clk_i) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rd_data_q <= mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      val_q  <= in_value_i;
      last_q <= in_last_i;
    end
    if (cmd_i.put) begin
      cmp_q <= {sum_cnt[CNT_W-2:0], 1'b1};
      asg_q <= CNT_W'({sum_cnt, 1'b0}) + sum_cnt + CNT_W'(1);
    end
    // counts travel with the output register so a new set cannot change a waiting transaction
    if (cmd_i.fl_ld) begin
      out_value_q <= rd_data_q;
      out_final_q <= status_o.k_last;
      out_cmp_q   <= cmp_q;
      out_asg_q   <= asg_q;
    end
  end

  always_comb begin
    pos_d       = pos_q;
    cnt_d       = cnt_q;
    shf_d       = shf_q;
    k_d         = k_q;
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) out_valid_d = 1'b0;
    if (cmd_i.load_in) pos_d = cnt_q[AW-1:0];
    if (cmd_i.shift) begin
      pos_d = pos_q - AW'(1);
      shf_d = shf_q + ST_W'(1);
    end
    if (cmd_i.put) begin
      cnt_d = cnt_inc;
      k_d   = '0;
    end
    if (cmd_i.fl_ld) begin
      k_d         = k_q + CW'(1);
      out_valid_d = 1'b1;
      if (status_o.k_last) begin
        // set done: store reads as empty again
        cnt_d = '0;
        shf_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      cnt_q       <= '0;
      shf_q       <= '0;
      k_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      pos_q       <= pos_d;
      cnt_q       <= cnt_d;
      shf_q       <= shf_d;
      k_q         <= k_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign status_o.pos_zero = (pos_q == '0);
  assign status_o.greater  = $signed(rd_data_q) > $signed(val_q);
  assign status_o.flush    = last_q | (cnt_inc == CW'(DEPTH));
  assign status_o.out_free = !out_valid_q | out_ready_i;
  assign status_o.k_last   = ((k_q + CW'(1)) == cnt_q);

  assign out_valid_o = out_valid_q;
  assign out_value_o = out_value_q;
  assign out_final_o = out_final_q;
  assign out_cmp_o   = out_cmp_q;
  assign out_asg_o   = out_asg_q;

endmodule

/* design/insertion_sort_with_op_counts_core.sv */
`timescale 1ns / 1ps
// Stable insertion sorter. Signed 32-bit values arrive one per input transaction and are
// placed in ascending order in an internal memory; equal values keep arrival order. When
// a transaction carries tlast, or the memory reaches DEPTH entries, the whole set is sent
// out in ascending order with tlast on the greatest element, and every output transaction
// also carries the set's compare count (2n+2I+1) and assignment count (3n+3I+1), both mod
// 2^13, for n elements and I shifts. Each item moves past the greater elements one at a time,
// compared through the single memory read port whose data is registered before each compare;
// a flush sends one element at a time and holds while the sink is not ready. No input is
// taken while a set is being sent out.
module insertion_sort_with_op_counts_core #(
  parameter int unsigned DEPTH = iswoc_pkg::DEPTH_DEFAULT
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [iswoc_pkg::DATA_W-1:0]        s_axis_tdata,  // value
  input  logic                                s_axis_tlast,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // sorted_value, compare_count, assign_count, zero pad
  output logic [iswoc_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
  output logic                                m_axis_tlast
);
  import iswoc_pkg::*;

  cmd_t              cmd;
  status_t           status;
  logic [DATA_W-1:0] out_value;
  logic [CNT_W-1:0]  out_cmp;
  logic [CNT_W-1:0]  out_asg;

  iswoc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  iswoc_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .in_value_i  (s_axis_tdata),
    .in_last_i   (s_axis_tlast),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_value_o (out_value),
    .out_final_o (m_axis_tlast),
    .out_cmp_o   (out_cmp),
    .out_asg_o   (out_asg)
  );

  assign m_axis_tdata = {{(OUT_TDATA_W - DATA_W - 2 * CNT_W){1'b0}}, out_asg, out_cmp, out_value};

endmodule

/* sim/tb_top.sv */
`timescale 1ns / 1ps
module tb_top;
  import iswoc_pkg::*;

  localparam int unsigned SORT_DEPTH     = DEPTH_DEFAULT;
  localparam int unsigned WATCHDOG_LIMIT = 5000;
  localparam int unsigned REPORT_CAP     = 200;
  localparam int unsigned RANDOM_ITEMS   = 210;

  typedef struct {
    logic signed [DATA_W-1:0] sorted_value;
    logic                     final_res;
    logic [CNT_W-1:0]         compare_count;
    logic [CNT_W-1:0]         assign_count;
  } sorted_res_t;

  class sort_scoreboard;
    sorted_res_t              expected_q[$];
    logic signed [DATA_W-1:0] sorted_store[SORT_DEPTH];
    int unsigned              held_count;
    int unsigned              shift_count;
    int unsigned              error_count;
    int unsigned              reported;

    function new();
      held_count  = 0;
      shift_count = 0;
      error_count = 0;
      reported    = 0;
    endfunction

    // insert one element; a tlast or a full store releases the whole set
    function void note_element(logic signed [DATA_W-1:0] val, logic lst);
      int unsigned pos;
      int unsigned k;
      sorted_res_t res;
      pos = held_count;
      while (pos > 0 && sorted_store[pos-1] > val) begin
        sorted_store[pos] = sorted_store[pos-1];
        pos--;
        shift_count++;
      end
      sorted_store[pos] = val;
      held_count++;
      if (lst || held_count == SORT_DEPTH) begin
        for (k = 0; k < held_count; k++) begin
          res.sorted_value  = sorted_store[k];
          res.final_res     = (k + 1 == held_count);
          res.compare_count = CNT_W'(2 * held_count + 2 * shift_count + 1);
          res.assign_count  = CNT_W'(3 * held_count + 3 * shift_count + 1);
          expected_q.push_back(res);
        end
        held_count  = 0;
        shift_count = 0;
      end
    endfunction

    function void report_field(string name, longint unsigned exp_v, longint unsigned act_v);
      error_count++;
      if (reported < REPORT_CAP) begin
        reported++;
        $error("%s mismatch: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
      end
    endfunction

    function void check_output(logic [OUT_TDATA_W-1:0] data, logic lst);
      sorted_res_t exp_r;
      if (expected_q.size() == 0) begin
        error_count++;
        if (reported < REPORT_CAP) begin
          reported++;
          $error("unexpected output transaction: tdata 0x%0h tlast %0b", data, lst);
        end
        return;
      end
      exp_r = expected_q.pop_front();
      if (data[DATA_W-1:0] !== exp_r.sorted_value)
        report_field("sorted_value", exp_r.sorted_value, data[DATA_W-1:0]);
      if (lst !== exp_r.final_res)
        report_field("final_res", exp_r.final_res, lst);
      if (data[DATA_W +: CNT_W] !== exp_r.compare_count)
        report_field("compare_count", exp_r.compare_count, data[DATA_W +: CNT_W]);
      if (data[DATA_W+CNT_W +: CNT_W] !== exp_r.assign_count)
        report_field("assign_count", exp_r.assign_count, data[DATA_W+CNT_W +: CNT_W]);
      if (data[OUT_TDATA_W-1:DATA_W+2*CNT_W] !== '0)
        report_field("pad", 0, data[OUT_TDATA_W-1:DATA_W+2*CNT_W]);
    endfunction
  endclass

  logic                   clk_i;
  logic                   rst_ni;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [DATA_W-1:0]      s_axis_tdata;
  logic                   s_axis_tlast;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   m_axis_tlast;

  logic                   src_idle;
  logic                   sink_idle;
  int unsigned            quiet_cycles;
  sort_scoreboard         sb;

  insertion_sort_with_op_counts_core u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    clk_i = 1'b1;
    #1;
    clk_i = 1'b0;
    #1;
  end

  // called at a falling edge; returns at the falling edge after the transaction
  task automatic send_element(input logic [DATA_W-1:0] val, input logic lst);
    int unsigned gap;
    gap = src_idle ? $urandom_range(0, 8) : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= val;
    s_axis_tlast  <= lst;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_element(val, lst);
    @(negedge clk_i);
  endtask

  task automatic send_set(input logic [DATA_W-1:0] vals[$]);
    int unsigned i;
    for (i = 0; i < vals.size(); i++)
      send_element(vals[i], i == vals.size() - 1);
  endtask

  // result side
  initial begin
    int unsigned stall;
    m_axis_tready = 1'b0;
    wait (rst_ni === 1'b1);
    @(negedge clk_i);
    forever begin
      stall = sink_idle ? $urandom_range(0, 8) : 0;
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      sb.check_output(m_axis_tdata, m_axis_tlast);
      @(negedge clk_i);
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    logic [DATA_W-1:0] vals[$];
    logic [DATA_W-1:0] v;
    logic              lst;
    int unsigned       random_sent;
    int unsigned       set_len;
    int unsigned       mode;
    int unsigned       i;
    logic              tail_last;

    sb            = new();
    quiet_cycles  = 0;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tlast  = 1'b0;
    src_idle      = 1'b0;
    sink_idle     = 1'b0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // extremes of the value range
    vals = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'hFFFF_FFFF, 32'h1,
             32'h8000_0001, 32'h7FFF_FFFE};
    send_set(vals);
    // a set of one
    vals = '{32'h5A5A_A5A5};
    send_set(vals);
    // equal values must keep arrival order
    vals = '{32'd5, 32'd5, -32'sd3, 32'd5, -32'sd3};
    send_set(vals);
    // already ascending: no shifts
    vals = '{-32'sd2, -32'sd1, 32'd0, 32'd1};
    send_set(vals);
    // descending: every element shifts past all the ones before it
    vals = '{32'd5, 32'd4, 32'd3, 32'd2, 32'd1};
    send_set(vals);

    // full store without tlast, strictly descending for the largest counts
    src_idle  = 1'b1;
    sink_idle = 1'b1;
    for (i = 0; i < SORT_DEPTH; i++)
      send_element(32'h7FFF_FFFF - i, 1'b0);

    random_sent = 0;
    while (random_sent < RANDOM_ITEMS) begin
      src_idle  = ($urandom_range(0, 2) != 0);
      sink_idle = ($urandom_range(0, 2) != 0);
      set_len   = ($urandom_range(0, 11) == 0) ? SORT_DEPTH : $urandom_range(1, 12);
      mode      = $urandom_range(0, 2);
      tail_last = $urandom_range(0, 1);
      for (i = 0; i < set_len; i++) begin
        case (mode)
          0: v = $urandom;
          // narrow range gives plenty of ties
          1: v = $urandom_range(0, 8) - 4;
          default: begin
            case ($urandom_range(0, 3))
              0:       v = 32'h7FFF_FFFF;
              1:       v = 32'h8000_0000;
              2:       v = $urandom & 32'h8000_000F;
              default: v = $urandom_range(0, 3);
            endcase
          end
        endcase
        if (i != set_len - 1)
          lst = 1'b0;
        else
          lst = (set_len == SORT_DEPTH) ? tail_last : 1'b1;
        send_element(v, lst);
      end
      random_sent += set_len;
    end
    s_axis_tvalid <= 1'b0;

    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (4 * SORT_DEPTH) @(posedge clk_i);

    if (sb.error_count == 0 && sb.expected_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

/* sim.f */
design/iswoc_pkg.sv
design/iswoc_ctrl.sv
design/iswoc_dp.sv
design/insertion_sort_with_op_counts_core.sv
sim/tb_top.sv
